// ===== rtl/command_packet_deframer_core_macros.svh =====
// assertion macros for the command packet deframer checker
// expects signals clk and rst_n in the scope of use
`ifndef COMMAND_PACKET_DEFRAMER_CORE_MACROS_SVH
`define COMMAND_PACKET_DEFRAMER_CORE_MACROS_SVH

// checked only while out of reset
`define CPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define CPD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/cpd_pkg.sv =====
// shared types, codes and header layout for the command packet deframer
// no dependencies
package cpd_pkg;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65535;
  localparam int          TDATA_W       = 160;

  localparam logic [5:0] POS_LEN        = 6'd4;
  localparam logic [5:0] POS_LEN_LAST   = 6'd7;
  localparam logic [5:0] POS_SEQ        = 6'd8;
  localparam logic [5:0] POS_CMD_HI     = 6'd16;
  localparam logic [5:0] POS_CMD_LO     = 6'd17;
  localparam logic [5:0] POS_SIGN_FIRST = 6'd18;
  localparam logic [5:0] POS_SIGN_LAST  = 6'd45;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_SIGN    = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic {
    ERR_MAGIC  = 1'b0,
    ERR_LENGTH = 1'b1
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [31:0] byte_offset;
    logic [31:0] payload_length;
    logic [63:0] sequence_number;
    logic [15:0] command_code;
    err_t        error_code;
    logic        last;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = 8'hCD;
      2'd1:    val = 8'h63;
      2'd2:    val = 8'h1D;
      default: val = 8'h9A;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/cpd_skid.sv =====
// two-entry skid buffer with a registered ready toward the upstream side
// generic width, no package dependency
module cpd_skid #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [WIDTH-1:0] s_data,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [WIDTH-1:0] m_data
);

  logic             main_valid_r;
  logic [WIDTH-1:0] main_data_r;
  logic             skid_valid_r;
  logic [WIDTH-1:0] skid_data_r;

  assign s_ready = !skid_valid_r;
  assign m_valid = main_valid_r;
  assign m_data  = main_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (m_ready || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        main_data_r  <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= s_valid;
        main_data_r  <= s_data;
      end
    end else if (s_valid && s_ready) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= s_data;
    end
  end

endmodule

// ===== rtl/cpd_parser.sv =====
// header parser and pass-through logic, one byte per cycle while res_ready is high
// depends on cpd_pkg
module cpd_parser import cpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  byte_data,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  logic [31:0] max_len_r;
  logic [5:0]  pos_r,       pos_nxt;
  logic        in_payload_r, in_payload_nxt;
  logic [31:0] length_r,    length_nxt;
  logic [31:0] remaining_r, remaining_nxt;
  logic [31:0] pay_off_r,   pay_off_nxt;
  logic [63:0] seq_r,       seq_nxt;
  logic [7:0]  cmd_hi_r,    cmd_hi_nxt;
  logic        take;
  logic        has_res;

  assign byte_ready = res_ready;
  assign take       = byte_valid && res_ready;
  assign res_valid  = take && has_res;

  always_comb begin
    pos_nxt        = pos_r;
    in_payload_nxt = in_payload_r;
    length_nxt     = length_r;
    remaining_nxt  = remaining_r;
    pay_off_nxt    = pay_off_r;
    seq_nxt        = seq_r;
    cmd_hi_nxt     = cmd_hi_r;
    res            = '0;
    has_res        = 1'b0;
    if (take) begin
      priority if (in_payload_r) begin
        has_res          = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.byte_value   = byte_data;
        res.byte_offset  = pay_off_r;
        remaining_nxt    = remaining_r - 32'd1;
        pay_off_nxt      = pay_off_r + 32'd1;
        if (remaining_r == 32'd1) begin
          res.last       = 1'b1;
          in_payload_nxt = 1'b0;
          pos_nxt        = '0;
        end
      end else if (pos_r < POS_LEN) begin
        if (byte_data == magic_byte(pos_r[1:0])) begin
          pos_nxt = pos_r + 6'd1;
        end else begin
          has_res        = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_MAGIC;
          pos_nxt        = (byte_data == magic_byte(2'd0)) ? 6'd1 : 6'd0;
        end
      end else if (pos_r < POS_SEQ) begin
        length_nxt = {length_r[23:0], byte_data};
        if (pos_r == POS_LEN_LAST && length_nxt > max_len_r) begin
          has_res            = 1'b1;
          res.kind           = KIND_ERROR;
          res.error_code     = ERR_LENGTH;
          res.payload_length = length_nxt;
          pos_nxt            = '0;
        end else begin
          pos_nxt = pos_r + 6'd1;
        end
      end else if (pos_r < POS_CMD_HI) begin
        seq_nxt = {seq_r[55:0], byte_data};
        pos_nxt = pos_r + 6'd1;
      end else if (pos_r == POS_CMD_HI) begin
        cmd_hi_nxt = byte_data;
        pos_nxt    = POS_CMD_LO;
      end else if (pos_r == POS_CMD_LO) begin
        has_res             = 1'b1;
        res.kind            = KIND_HEADER;
        res.payload_length  = length_r;
        res.sequence_number = seq_r;
        res.command_code    = {cmd_hi_r, byte_data};
        pos_nxt             = POS_SIGN_FIRST;
      end else begin
        has_res         = 1'b1;
        res.kind        = KIND_SIGN;
        res.byte_value  = byte_data;
        res.byte_offset = {26'd0, pos_r - POS_SIGN_FIRST};
        if (pos_r >= POS_SIGN_LAST) begin
          if (length_r == 32'd0) begin
            res.last = 1'b1;
          end else begin
            in_payload_nxt = 1'b1;
            remaining_nxt  = length_r;
            pay_off_nxt    = '0;
          end
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= MAX_LEN_RESET;
      pos_r        <= '0;
      in_payload_r <= 1'b0;
      length_r     <= '0;
      remaining_r  <= '0;
      pay_off_r    <= '0;
      seq_r        <= '0;
      cmd_hi_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      pos_r        <= pos_nxt;
      in_payload_r <= in_payload_nxt;
      length_r     <= length_nxt;
      remaining_r  <= remaining_nxt;
      pay_off_r    <= pay_off_nxt;
      seq_r        <= seq_nxt;
      cmd_hi_r     <= cmd_hi_nxt;
    end
  end

endmodule

// ===== rtl/command_packet_deframer_core.sv =====
// top level of the command packet deframer
// depends on cpd_pkg, cpd_skid and cpd_parser
//
// Takes one packet byte per request and gives at most one result per byte.
// Header: magic CD 63 1D 9A, 32-bit length, 64-bit sequence, 16-bit command
// (all big-endian) and a 28-byte signature, then the payload. A header
// result follows the last command byte; each signature and payload byte then
// comes out with its offset, the final byte of the packet with tlast. A bad
// magic byte or a length above cfg_wr_data's last written limit (reset 65535)
// gives an error result and the parser hunts for magic again. Throughput is
// one byte per cycle while out_tready is high: a skid buffer on the input
// feeds the combinational parser, whose result is caught by a skid buffer on
// the output, so each byte is registered on input and its result on output,
// and in_tready is a registered signal.
module command_packet_deframer_core import cpd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // data_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  // byte_value, byte_offset, payload_length, sequence_number, command_code,
  // error_code, zero fill
  output logic [TDATA_W-1:0] out_tdata,
  output logic [1:0]         out_tuser,  // kind
  output logic               out_tlast   // last
);

  logic       byte_valid;
  logic       byte_ready;
  logic [7:0] byte_data;
  logic       res_valid;
  logic       res_ready;
  result_t    res;
  result_t    out_res;

  cpd_skid #(
    .WIDTH(8)
  ) u_in_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (in_tdata),
    .m_valid (byte_valid),
    .m_ready (byte_ready),
    .m_data  (byte_data)
  );

  cpd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_data   (byte_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  cpd_skid #(
    .WIDTH($bits(result_t))
  ) u_out_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (res_valid),
    .s_ready (res_ready),
    .s_data  (res),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_res)
  );

  assign out_tdata = {7'd0, out_res.error_code, out_res.command_code,
                      out_res.sequence_number, out_res.payload_length,
                      out_res.byte_offset, out_res.byte_value};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

// ===== rtl/cpd_checker.sv =====
// port-level checker for the command packet deframer, with its bind
// depends on cpd_pkg and command_packet_deframer_core_macros.svh
`include "command_packet_deframer_core_macros.svh"

module cpd_checker import cpd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic [1:0]         out_tuser,
  input logic               out_tlast
);

  // stalled result holds
  `CPD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // tlast only on a passed-through byte
  `CPD_ASSERT(a_last_kind, out_tvalid && out_tlast |-> out_tuser == KIND_SIGN || out_tuser == KIND_PAYLOAD)

  // header and error results carry no byte or offset
  `CPD_ASSERT(a_no_byte, out_tvalid && (out_tuser == KIND_HEADER || out_tuser == KIND_ERROR) |-> out_tdata[39:0] == 40'd0)

  // clean start after reset
  `CPD_ASSERT_ALWAYS(a_reset_idle, rst_n && $past(!rst_n) |-> !out_tvalid && in_tready)

endmodule

bind command_packet_deframer_core cpd_checker u_cpd_checker (.*);
